>>> design/smcf_pkg.sv
package smcf_pkg;

  localparam int PAT_MAX_DEF = 8;
  localparam int PAT_BYTES   = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int LEN_W       = 4;
  localparam int POS_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD    = 2'd2;

  localparam logic [8:0] FOLD_DIST = 9'd32;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
    logic [9:0] record_index;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [9:0] result_index;
  } out_t;

  typedef struct packed {
    logic                 shift;
    logic                 clear;
    logic                 fold;
    logic [LEN_W-1:0]     eff_len;
    logic [CFG_W-1:0]     pattern;
  } ctrl_t;

  function automatic logic byte_match(input logic [7:0] t, input logic [7:0] p,
                                      input logic fold);
    logic [8:0] tw;
    logic [8:0] pw;
    tw = {1'b0, t};
    pw = {1'b0, p};
    byte_match = (t == p) || (fold && ((tw + FOLD_DIST == pw) || (pw + FOLD_DIST == tw)));
  endfunction

  function automatic logic [7:0] pattern_at(input logic [CFG_W-1:0] pattern,
                                            input logic [POS_W-1:0] pos);
    pattern_at = pattern[{pos, 3'b000} +: 8];
  endfunction

endpackage

>>> design/smcf_cell.sv
module smcf_cell #(
  parameter int CELL_IDX = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  smcf_pkg::ctrl_t     ctrl,
  input  logic [7:0]          byte_in,
  input  logic                valid_in,
  input  logic                ok_in,
  output logic [7:0]          byte_out,
  output logic                valid_out,
  output logic                ok_out
);

  logic [7:0]                   byte_r;
  logic                         valid_r;
  logic                         enabled;
  logic [smcf_pkg::LEN_W-1:0]   pos_full;
  logic [7:0]                   pat_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= byte_in;
    end
  end

  // This cell sits CELL_IDX bytes back from the newest one.
  assign enabled  = ctrl.eff_len > smcf_pkg::LEN_W'(CELL_IDX);
  assign pos_full = ctrl.eff_len - smcf_pkg::LEN_W'(1) - smcf_pkg::LEN_W'(CELL_IDX);
  assign pat_byte = smcf_pkg::pattern_at(ctrl.pattern, pos_full[smcf_pkg::POS_W-1:0]);

  assign ok_out    = ok_in &
                     (!enabled | (valid_r & smcf_pkg::byte_match(byte_r, pat_byte, ctrl.fold)));
  assign byte_out  = byte_r;
  assign valid_out = valid_r;

endmodule

>>> design/substring_match_case_fold_top.sv
// Streaming substring detector: one text byte is taken every clock cycle, with no gaps
// between texts, while the result register is free or being emptied. Each byte is
// compared at once against the configured pattern through a chain of PAT_MAX-1 history
// cells, each holding one earlier byte and comparing it with its pattern position; the
// newest byte is compared at the head of the chain. On the byte marked last, the result
// (found flag and record index) appears on the output in the next cycle and the history
// clears for the next text. Only a window lying fully inside the current text counts.
// Configuration writes take effect for the next byte.
module substring_match_case_fold_top #(
  parameter int PAT_MAX = smcf_pkg::PAT_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  smcf_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output smcf_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [smcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smcf_pkg::CFG_W-1:0]        cfg_data
);

  logic [smcf_pkg::CFG_W-1:0]  pattern_r;
  logic [smcf_pkg::LEN_W-1:0]  length_r;
  logic                        fold_r;
  logic [smcf_pkg::LEN_W-1:0]  eff_len;
  logic [smcf_pkg::LEN_W-1:0]  head_pos;
  logic                        found_r;
  logic                        found_nxt;
  logic                        out_valid_r;
  smcf_pkg::out_t              out_data_r;
  smcf_pkg::ctrl_t             ctrl;
  logic                        in_acc;
  logic                        hit;

  logic [7:0] byte_c  [PAT_MAX];
  logic       valid_c [PAT_MAX];
  logic       ok_c    [PAT_MAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= smcf_pkg::LEN_W'(1);
      fold_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        smcf_pkg::REG_PATTERN: pattern_r <= cfg_data;
        smcf_pkg::REG_LENGTH:  length_r  <= cfg_data[smcf_pkg::LEN_W-1:0];
        smcf_pkg::REG_FOLD:    fold_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (length_r == '0) begin
      eff_len = smcf_pkg::LEN_W'(1);
    end else if (length_r > smcf_pkg::LEN_W'(PAT_MAX)) begin
      eff_len = smcf_pkg::LEN_W'(PAT_MAX);
    end else begin
      eff_len = length_r;
    end
  end

  assign in_ready = !out_valid_r | out_ready;
  assign in_acc   = in_valid & in_ready;

  assign ctrl.shift   = in_acc & !in_data.text_last;
  assign ctrl.clear   = in_acc & in_data.text_last;
  assign ctrl.fold    = fold_r;
  assign ctrl.eff_len = eff_len;
  assign ctrl.pattern = pattern_r;

  // Head of the chain: newest byte against the last pattern position.
  assign head_pos   = eff_len - smcf_pkg::LEN_W'(1);
  assign byte_c[0]  = in_data.text_byte;
  assign valid_c[0] = 1'b1;
  assign ok_c[0]    = smcf_pkg::byte_match(in_data.text_byte,
                        smcf_pkg::pattern_at(pattern_r, head_pos[smcf_pkg::POS_W-1:0]),
                        fold_r);

  for (genvar k = 1; k < PAT_MAX; k++) begin : g_cell
    smcf_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .byte_in   (byte_c[k-1]),
      .valid_in  (valid_c[k-1]),
      .ok_in     (ok_c[k-1]),
      .byte_out  (byte_c[k]),
      .valid_out (valid_c[k]),
      .ok_out    (ok_c[k])
    );
  end

  assign hit       = ok_c[PAT_MAX-1];
  assign found_nxt = found_r | hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.clear) begin
      found_r <= 1'b0;
    end else if (ctrl.shift) begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      out_data_r.found        <= found_nxt;
      out_data_r.result_index <= in_data.record_index;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/smcf_checker.sv
module smcf_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  smcf_pkg::in_t   in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  smcf_pkg::out_t  out_data
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.text_last |=>
      out_valid && (out_data.result_index == $past(in_data.record_index)))
    else $error("last text beat did not produce its result");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result register is full");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready && in_data.text_last) |=> !out_valid)
    else $error("result beat without a last text beat");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind substring_match_case_fold_top smcf_checker u_smcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
